[sv/jpeg_progressive_marker_scan_top_macros.svh]
// Assertion macros shared by the marker scan RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef JPEG_PROGRESSIVE_MARKER_SCAN_TOP_MACROS_SVH
`define JPEG_PROGRESSIVE_MARKER_SCAN_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JPMS_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define JPMS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[sv/jpms_pkg.sv]
// Types, marker codes and marker classification for the JPEG marker scan.
// No dependencies; used by jpms_walk and jpeg_progressive_marker_scan_top.
`default_nettype none

package jpms_pkg;

   localparam int DATA_W    = 8;
   localparam int LEN_W     = 24;
   localparam int SEG_W     = 16;
   localparam int OUT_IDX_W = 24;

   localparam logic [DATA_W-1:0] MARKER_PREFIX = 8'hFF;
   localparam logic [DATA_W-1:0] MARKER_SOI    = 8'hD8;
   localparam logic [DATA_W-1:0] MARKER_TEM    = 8'h01;
   localparam logic [DATA_W-1:0] MARKER_RST0   = 8'hD0;
   localparam logic [DATA_W-1:0] MARKER_EOI    = 8'hD9;
   localparam logic [DATA_W-1:0] MARKER_SOS    = 8'hDA;
   localparam logic [DATA_W-1:0] MARKER_SOF2   = 8'hC2;
   localparam logic [DATA_W-1:0] MARKER_SOF6   = 8'hC6;
   localparam logic [DATA_W-1:0] MARKER_SOF10  = 8'hCA;
   localparam logic [DATA_W-1:0] MARKER_SOF0   = 8'hC0;
   localparam logic [DATA_W-1:0] MARKER_SOF1   = 8'hC1;
   localparam logic [DATA_W-1:0] MARKER_SOF3   = 8'hC3;
   localparam logic [DATA_W-1:0] MARKER_SOF5   = 8'hC5;
   localparam logic [DATA_W-1:0] MARKER_SOF7   = 8'hC7;
   localparam logic [DATA_W-1:0] MARKER_SOF9   = 8'hC9;
   localparam logic [DATA_W-1:0] MARKER_SOF11  = 8'hCB;
   localparam logic [DATA_W-1:0] MARKER_SOF13  = 8'hCD;
   localparam logic [DATA_W-1:0] MARKER_SOF14  = 8'hCE;
   localparam logic [DATA_W-1:0] MARKER_SOF15  = 8'hCF;

   localparam logic [LEN_W-1:0] MIN_STREAM_LEN = 24'd4;
   localparam logic [SEG_W-1:0] MIN_SEG_LEN    = 16'd2;

   typedef enum logic [2:0] {
      PH_SOI0  = 3'd0,
      PH_SOI1  = 3'd1,
      PH_MARK  = 3'd2,
      PH_FILL  = 3'd3,
      PH_LENHI = 3'd4,
      PH_LENLO = 3'd5,
      PH_SKIP  = 3'd6
   } phase_type;

   typedef struct packed {
      logic                 valid;
      logic                 progressive;
      logic [OUT_IDX_W-1:0] at;
   } verdict_type;

   function automatic logic is_standalone(input logic [DATA_W-1:0] m);
      return (m == MARKER_TEM) || ((m >= MARKER_RST0) && (m <= MARKER_EOI));
   endfunction

   function automatic logic is_prog_frame(input logic [DATA_W-1:0] m);
      return (m == MARKER_SOF2) || (m == MARKER_SOF6) || (m == MARKER_SOF10);
   endfunction

   function automatic logic is_seq_frame(input logic [DATA_W-1:0] m);
      return (m == MARKER_SOF0)  || (m == MARKER_SOF1)  || (m == MARKER_SOF3)  ||
             (m == MARKER_SOF5)  || (m == MARKER_SOF7)  || (m == MARKER_SOF9)  ||
             (m == MARKER_SOF11) || (m == MARKER_SOF13) || (m == MARKER_SOF14) ||
             (m == MARKER_SOF15);
   endfunction

endpackage

`default_nettype wire

[sv/jpms_walk.sv]
// Marker segment walker: scan state, byte counter and per-byte verdict logic.
// Depends on jpms_pkg and the assertion macro header.
`default_nettype none
`include "jpeg_progressive_marker_scan_top_macros.svh"

module jpms_walk #(
   parameter int INDEX_BITS = 24
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,
   input  wire logic [jpms_pkg::DATA_W-1:0]  data_byte,
   input  wire logic                         last_byte,
   input  wire logic [jpms_pkg::LEN_W-1:0]   stream_length,
   output jpms_pkg::verdict_type             verdict
);
   import jpms_pkg::*;

   // Compare width: holds any index or length plus a segment length.
   localparam int BASE_W = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;
   localparam int CW     = BASE_W + 1;
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

   phase_type             phase_ff, phase_in;
   logic [INDEX_BITS-1:0] byte_index_ff, byte_index_in;
   logic [SEG_W-1:0]      skip_ff, skip_in;
   logic [DATA_W-1:0]     marker_ff, marker_in;
   logic [DATA_W-1:0]     length_high_ff, length_high_in;
   logic                  given_ff, given_in;

   logic [CW-1:0]    idx_ext, len_ext, idx_plus1, len_plus1, seg_end;
   logic [SEG_W-1:0] seg_len, seg_body;
   logic             near_end, past_end, seg_bad;
   logic             walk_hit, walk_value;

   assign idx_ext   = {{(CW-INDEX_BITS){1'b0}}, byte_index_ff};
   assign len_ext   = {{(CW-LEN_W){1'b0}}, stream_length};
   assign idx_plus1 = idx_ext + CW'(1);
   assign len_plus1 = len_ext + CW'(1);
   assign seg_len   = {length_high_ff, data_byte};
   assign seg_body  = seg_len - MIN_SEG_LEN;
   assign seg_end   = idx_ext + {{(CW-SEG_W){1'b0}}, seg_len};
   assign near_end  = idx_plus1 >= len_ext;
   assign past_end  = idx_ext >= len_ext;
   // The segment starts at the first length byte, one before this one.
   assign seg_bad   = (seg_len < MIN_SEG_LEN) || (seg_end > len_plus1);

   // Verdict of the walk on this byte, before the early-end rule.
   always_comb begin
      walk_hit   = 1'b0;
      walk_value = 1'b0;
      unique case (phase_ff)
         PH_SOI0: walk_hit = (stream_length < MIN_STREAM_LEN) ||
                             (data_byte != MARKER_PREFIX);
         PH_SOI1: walk_hit = data_byte != MARKER_SOI;
         PH_MARK: walk_hit = near_end || (data_byte != MARKER_PREFIX);
         PH_FILL: walk_hit = past_end ||
                             ((data_byte != MARKER_PREFIX) && !is_standalone(data_byte) &&
                              (data_byte == MARKER_SOS));
         PH_LENHI: walk_hit = near_end;
         PH_LENLO: begin
            if (seg_bad) begin
               walk_hit = 1'b1;
            end else if (is_prog_frame(marker_ff)) begin
               walk_hit   = 1'b1;
               walk_value = 1'b1;
            end else begin
               walk_hit = is_seq_frame(marker_ff);
            end
         end
         PH_SKIP: walk_hit = 1'b0;
         default: walk_hit = 1'b1;
      endcase
   end

   always_comb begin
      verdict.valid       = step && !given_ff && (walk_hit || last_byte);
      verdict.progressive = walk_hit && walk_value;
      verdict.at          = idx_ext[OUT_IDX_W-1:0];
   end

   // Next scan state.
   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      skip_in        = skip_ff;
      marker_in      = marker_ff;
      length_high_in = length_high_ff;
      given_in       = given_ff;
      if (step) begin
         if (!given_ff) begin
            given_in = walk_hit || last_byte;
            unique case (phase_ff)
               PH_SOI0: if (!walk_hit) phase_in = PH_SOI1;
               PH_SOI1: if (!walk_hit) phase_in = PH_MARK;
               PH_MARK: if (!walk_hit) phase_in = PH_FILL;
               PH_FILL: begin
                  if (!past_end && (data_byte != MARKER_PREFIX)) begin
                     marker_in = data_byte;
                     if (is_standalone(data_byte)) begin
                        phase_in = PH_MARK;
                     end else if (data_byte != MARKER_SOS) begin
                        phase_in = PH_LENHI;
                     end
                  end
               end
               PH_LENHI: begin
                  if (!walk_hit) begin
                     length_high_in = data_byte;
                     phase_in       = PH_LENLO;
                  end
               end
               PH_LENLO: begin
                  if (!walk_hit) begin
                     skip_in  = seg_body;
                     phase_in = (seg_body == '0) ? PH_MARK : PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  skip_in = skip_ff - SEG_W'(1);
                  if (skip_in == '0) phase_in = PH_MARK;
               end
               default: phase_in = phase_ff;
            endcase
         end
         if (last_byte) begin
            phase_in       = PH_SOI0;
            byte_index_in  = '0;
            skip_in        = '0;
            marker_in      = '0;
            length_high_in = '0;
            given_in       = 1'b0;
         end else if (byte_index_ff != INDEX_MAX) begin
            byte_index_in = byte_index_ff + INDEX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SOI0;
         byte_index_ff  <= '0;
         skip_ff        <= '0;
         marker_ff      <= '0;
         length_high_ff <= '0;
         given_ff       <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         skip_ff        <= skip_in;
         marker_ff      <= marker_in;
         length_high_ff <= length_high_in;
         given_ff       <= given_in;
      end
   end

   `JPMS_ASSERT_NEXT(a_rearm, clock, reset, step && last_byte,
      (phase_ff == PH_SOI0) && (byte_index_ff == '0) && !given_ff,
      "last byte did not re-arm the scan")
   `JPMS_ASSERT_NOW(a_one_verdict, clock, reset, given_ff, !verdict.valid,
      "second verdict within one image")
   `JPMS_ASSERT_NOW(a_end_verdict, clock, reset, step && last_byte && !given_ff,
      verdict.valid, "image ended without a verdict")

endmodule

`default_nettype wire

[sv/jpeg_progressive_marker_scan_top.sv]
// A verdict is registered and appears on the result port in the cycle after the byte that decides it.
// Throughput: one byte per cycle; the result register frees on the same cycle it transfers.
// A byte is refused only while an unaccepted result sits in the result register.
// Reset (synchronous, active high) clears the scan state, the result valid and stream_length.
// Top level of the JPEG progressive marker scan; depends on jpms_pkg and jpms_walk.
`default_nettype none
`include "jpeg_progressive_marker_scan_top_macros.svh"

module jpeg_progressive_marker_scan_top #(
   parameter int INDEX_BITS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [jpms_pkg::LEN_W-1:0]      csr_wr_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [jpms_pkg::DATA_W-1:0]     req_data_byte,
   input  wire logic                            req_last_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_is_progressive,
   output logic [jpms_pkg::OUT_IDX_W-1:0]       rsp_decided_at
);
   import jpms_pkg::*;

   logic [LEN_W-1:0]     stream_length_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_prog_ff;
   logic [OUT_IDX_W-1:0] rsp_at_ff;
   logic                 req_xfer;
   verdict_type          verdict;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   jpms_walk #(
      .INDEX_BITS (INDEX_BITS)
   ) u_walk (
      .clock         (clock),
      .reset         (reset),
      .step          (req_xfer),
      .data_byte     (req_data_byte),
      .last_byte     (req_last_byte),
      .stream_length (stream_length_ff),
      .verdict       (verdict)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = verdict.valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_length_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) stream_length_ff <= csr_wr_data;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && verdict.valid) begin
         rsp_prog_ff <= verdict.progressive;
         rsp_at_ff   <= verdict.at;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_progressive = rsp_prog_ff;
   assign rsp_decided_at     = rsp_at_ff;

   `JPMS_ASSERT_NEXT(a_verdict_shown, clock, reset, req_xfer && verdict.valid,
      rsp_valid_ff, "verdict did not reach the result register")
   `JPMS_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready,
      !req_ready, "byte taken while a result is stalled")
   `JPMS_ASSERT_NEXT(a_no_phantom, clock, reset, !req_xfer && !rsp_valid_ff,
      !rsp_valid_ff, "result appeared without a byte transfer")

endmodule

`default_nettype wire

[tb/sv/tb_jpeg_progressive_marker_scan_top.sv]
// Self-checking testbench for jpeg_progressive_marker_scan_top: directed marker walks,
// random well-formed and damaged images under idle/stall phases, and a long result stall.
// Depends on jpms_pkg and the top-level RTL only.
module tb_jpeg_progressive_marker_scan_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jpms_pkg::*;

   localparam int INDEX_BITS = 24;

   // Verdict codes of the scanner's walk.
   localparam int VERDICT_NONE     = -1;
   localparam int VERDICT_NOT_PROG = 0;
   localparam int VERDICT_PROG     = 1;

   // Non-frame segment markers used to build images.
   localparam logic [7:0] MARKER_APP0 = 8'hE0;
   localparam logic [7:0] MARKER_DQT  = 8'hDB;
   localparam logic [7:0] MARKER_DHT  = 8'hC4;
   localparam logic [7:0] MARKER_COM  = 8'hFE;

   localparam int SETTLE_CYCLES = 3;
   localparam int DRAIN_LIMIT   = 20000;

   typedef struct {
      logic                  prog;
      logic [OUT_IDX_W-1:0]  at;
   } verdict_rec_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [LEN_W-1:0]      csr_wr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [DATA_W-1:0]     req_data_byte = '0;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_is_progressive;
   logic [OUT_IDX_W-1:0]  rsp_decided_at;

   // Predictor state.
   phase_type             walk_phase = PH_SOI0;
   logic [INDEX_BITS-1:0] walk_index = '0;
   logic [SEG_W-1:0]      seg_left = '0;
   logic [7:0]            seg_marker = '0;
   logic [7:0]            len_hi = '0;
   logic                  decided = 1'b0;
   logic [LEN_W-1:0]      stream_len = '0;

   verdict_rec_type pending_verdicts[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_left = 0;
   int mismatches = 0;
   int bytes_sent = 0;
   int verdicts_checked = 0;
   int prog_verdicts = 0;
   int length_writes = 0;

   jpeg_progressive_marker_scan_top #(
      .INDEX_BITS(INDEX_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_progressive (rsp_is_progressive),
      .rsp_decided_at     (rsp_decided_at)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Walks one byte through the marker segments and returns the verdict it causes, if any.
   function automatic int scan_byte(input logic [7:0] b, input longint unsigned i,
                                    input longint unsigned len);
      longint unsigned seg;
      case (walk_phase)
         PH_SOI0: begin
            if (len < MIN_STREAM_LEN || b != MARKER_PREFIX) return VERDICT_NOT_PROG;
            walk_phase = PH_SOI1;
         end
         PH_SOI1: begin
            if (b != MARKER_SOI) return VERDICT_NOT_PROG;
            walk_phase = PH_MARK;
         end
         PH_MARK: begin
            if (i + 1 >= len || b != MARKER_PREFIX) return VERDICT_NOT_PROG;
            walk_phase = PH_FILL;
         end
         PH_FILL: begin
            if (i >= len) return VERDICT_NOT_PROG;
            if (b == MARKER_PREFIX) return VERDICT_NONE;
            seg_marker = b;
            if (b == MARKER_TEM || (b >= MARKER_RST0 && b <= MARKER_EOI)) begin
               walk_phase = PH_MARK;
               return VERDICT_NONE;
            end
            if (b == MARKER_SOS) return VERDICT_NOT_PROG;
            walk_phase = PH_LENHI;
         end
         PH_LENHI: begin
            if (i + 1 >= len) return VERDICT_NOT_PROG;
            len_hi = b;
            walk_phase = PH_LENLO;
         end
         PH_LENLO: begin
            seg = {48'd0, len_hi, b};
            // The segment begins at the first length byte, one index back.
            if (seg < MIN_SEG_LEN || i + seg > len + 1) return VERDICT_NOT_PROG;
            case (seg_marker)
               MARKER_SOF2, MARKER_SOF6, MARKER_SOF10: return VERDICT_PROG;
               MARKER_SOF0, MARKER_SOF1, MARKER_SOF3, MARKER_SOF5, MARKER_SOF7,
               MARKER_SOF9, MARKER_SOF11, MARKER_SOF13, MARKER_SOF14, MARKER_SOF15:
                  return VERDICT_NOT_PROG;
               default: begin
                  seg_left = seg[SEG_W-1:0] - MIN_SEG_LEN;
                  walk_phase = (seg_left == '0) ? PH_MARK : PH_SKIP;
               end
            endcase
         end
         PH_SKIP: begin
            seg_left = seg_left - 1'b1;
            if (seg_left == '0) walk_phase = PH_MARK;
         end
         default: return VERDICT_NOT_PROG;
      endcase
      return VERDICT_NONE;
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic is_last);
      int v;
      v = VERDICT_NONE;
      if (!decided) begin
         v = scan_byte(b, walk_index, stream_len);
         if (v == VERDICT_NONE && is_last) v = VERDICT_NOT_PROG;
         if (v != VERDICT_NONE) begin
            pending_verdicts.push_back('{v == VERDICT_PROG, walk_index[OUT_IDX_W-1:0]});
            decided = 1'b1;
         end
      end
      if (is_last) begin
         walk_phase = PH_SOI0;
         walk_index = '0;
         seg_left = '0;
         seg_marker = '0;
         len_hi = '0;
         decided = 1'b0;
      end else if (walk_index != '1) begin
         walk_index = walk_index + 1'b1;
      end
   endfunction

   // Result side: random stalls, plus a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : check_verdicts
      verdict_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected verdict transfer: is_progressive %0b, decided_at %0d",
                   rsp_is_progressive, rsp_decided_at);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_is_progressive !== want.prog) begin
               $error("is_progressive: expected %0b, got %0b", want.prog, rsp_is_progressive);
               mismatches++;
            end
            if (rsp_decided_at !== want.at) begin
               $error("decided_at: expected %0d, got %0d", want.at, rsp_decided_at);
               mismatches++;
            end
            verdicts_checked++;
            if (want.prog) prog_verdicts++;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= is_last;
      do @(posedge clock); while (!req_ready);
      predict_byte(b, is_last);
      bytes_sent++;
   endtask

   task automatic send_image(input logic [7:0] img[$]);
      foreach (img[k]) send_byte(img[k], k == img.size() - 1);
   endtask

   // Lets every expected verdict arrive and the block go quiet.
   task automatic settle();
      int n;
      req_valid <= 1'b0;
      n = 0;
      while (pending_verdicts.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (pending_verdicts.size() != 0) begin
         $error("%0d verdicts never arrived", pending_verdicts.size());
         mismatches++;
         pending_verdicts.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [LEN_W-1:0] len);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      stream_len = len;
      length_writes++;
   endtask

   function automatic void build_image(ref logic [7:0] img[$]);
      int segs;
      int seglen;
      int cut;
      logic [7:0] mk;
      logic lone;
      img.delete();
      img.push_back(MARKER_PREFIX);
      img.push_back(MARKER_SOI);
      segs = $urandom_range(3);
      for (int s = 0; s <= segs; s++) begin
         img.push_back(MARKER_PREFIX);
         if ($urandom_range(3) == 0) img.push_back(MARKER_PREFIX);
         lone = 1'b0;
         if (s == segs) begin
            case ($urandom_range(3))
               0: mk = MARKER_SOS;
               1: mk = MARKER_SOF0 + 8'($urandom_range(15));
               default: begin
                  case ($urandom_range(2))
                     0: mk = MARKER_SOF2;
                     1: mk = MARKER_SOF6;
                     default: mk = MARKER_SOF10;
                  endcase
               end
            endcase
         end else if ($urandom_range(3) == 0) begin
            mk = ($urandom_range(1) == 0) ? MARKER_TEM : MARKER_RST0 + 8'($urandom_range(9));
            lone = 1'b1;
         end else begin
            case ($urandom_range(3))
               0: mk = MARKER_APP0 + 8'($urandom_range(15));
               1: mk = MARKER_DQT;
               2: mk = MARKER_DHT;
               default: mk = MARKER_COM;
            endcase
         end
         img.push_back(mk);
         if (!lone && mk != MARKER_SOS) begin
            // Now and then a wild length that may not fit in the image.
            seglen = ($urandom_range(9) == 0) ? int'($urandom_range(16'hFFFF)) :
                                                int'($urandom_range(2, 9));
            img.push_back(seglen[15:8]);
            img.push_back(seglen[7:0]);
            if (seglen >= 2 && seglen <= 9)
               repeat (seglen - 2) img.push_back(8'($urandom_range(255)));
         end
      end
      repeat ($urandom_range(4)) img.push_back(8'($urandom_range(255)));
      img.push_back(MARKER_PREFIX);
      img.push_back(MARKER_EOI);
      if ($urandom_range(5) == 0) img[$urandom_range(img.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(7) == 0) begin
         cut = $urandom_range(img.size() - 1);
         img = img[0:cut];
      end
   endfunction

   // Short images, bad start bytes and a fill run that runs past the stream length.
   task automatic test_stream_edges();
      settle();
      write_length('0);
      send_image('{MARKER_PREFIX});
      settle();
      write_length(MIN_STREAM_LEN);
      send_image('{8'h00});
      send_image('{MARKER_PREFIX, 8'h00});
      send_image('{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_PREFIX, MARKER_PREFIX});
      settle();
   endtask

   // Standalone markers, fill bytes, a progressive frame, bytes after the verdict, and a scan.
   task automatic test_marker_walk();
      write_length('1);
      send_image('{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_TEM, MARKER_PREFIX,
                   MARKER_PREFIX, MARKER_SOF2, 8'h00, 8'h02, MARKER_EOI});
      settle();
      write_length(24'd5);
      send_image('{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_SOS});
      settle();
   endtask

   // The length register changes between two bytes of one image.
   task automatic test_length_change();
      write_length(24'd6);
      send_byte(MARKER_PREFIX, 1'b0);
      send_byte(MARKER_SOI, 1'b0);
      settle();
      write_length(24'd3);
      send_byte(MARKER_PREFIX, 1'b1);
      settle();
   endtask

   task automatic test_random_images(input int idle_pct, input int stall_pct,
                                     input int byte_goal);
      logic [7:0] img[$];
      int first_byte;
      int first_verdict;
      int len;
      logic noise;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      first_byte = bytes_sent;
      first_verdict = verdicts_checked;
      while (bytes_sent - first_byte < byte_goal || verdicts_checked - first_verdict < 15) begin
         noise = ($urandom_range(4) == 0);
         if (noise) begin
            img.delete();
            repeat ($urandom_range(1, 6)) img.push_back(8'($urandom_range(255)));
         end else begin
            build_image(img);
         end
         case ($urandom_range(9))
            0: len = img.size() - $urandom_range(1, 3);
            1: len = img.size() + $urandom_range(1, 20);
            2: len = $urandom_range(24'hFFFFFF);
            3: len = $urandom_range(5);
            default: len = img.size();
         endcase
         if (len < 0) len = 0;
         if ($urandom_range(3) != 0) begin
            settle();
            write_length(LEN_W'(len));
         end
         // Noise may carry stray end-of-image flags in the middle.
         foreach (img[k])
            send_byte(img[k], k == img.size() - 1 || (noise && $urandom_range(3) == 0));
      end
      settle();
   endtask

   // The result side holds off while bytes keep coming, so the result register
   // fills and the input stalls.
   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      write_length(MIN_STREAM_LEN);
      hold_left = 300;
      repeat (40) send_byte(8'($urandom_range(255)), 1'b1);
      settle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_stream_edges();
      test_marker_walk();
      test_length_change();
      test_random_images(0, 0, 300);
      test_random_images(51, 0, 300);
      test_random_images(0, 51, 300);
      test_random_images(32, 32, 300);
      test_backpressure();
      $display("Run covered %0d stream bytes across %0d length settings.",
               bytes_sent, length_writes);
      $display("Checked %0d verdicts, %0d of them progressive.",
               verdicts_checked, prog_verdicts);
      if (mismatches == 0)
         $display("tb_jpeg_progressive_marker_scan_top: clean");
      else
         $display("tb_jpeg_progressive_marker_scan_top: errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out waiting for the block.");
      $display("tb_jpeg_progressive_marker_scan_top: errors");
      $finish;
   end

endmodule
